FILE: rtl/tmcw_pkg.sv
// Shared constants, codes and types of the text mode console writer.
`timescale 1ns / 1ps

package tmcw_pkg;

  // Screen geometry
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TOTAL    = COLUMNS * ROWS;
  localparam int CELL_W   = $clog2(TOTAL);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int CURSOR_W = 11;

  // Command queue between front and back (depth must be a power of two)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Character codes
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_BS      = 8'h08;
  localparam logic [7:0] CHAR_ERR     = 8'h45;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // Register reset values
  localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;
  localparam logic [7:0] ERROR_ATTR_RESET   = 8'd244;

  typedef enum logic {
    CFG_DEFAULT_ATTR = 1'b0,
    CFG_ERROR_ATTR   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_PUT       = 2'd0,
    KIND_BACKSPACE = 2'd1,
    KIND_CLEAR     = 2'd2,
    KIND_READ      = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_PUT_ERR,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_READ,
    OP_READ_ERR
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             use_pos;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic [7:0]          read_char;
    logic [7:0]          read_attr;
    logic [CURSOR_W-1:0] cursor_cell;
    logic                range_error;
    logic                scrolled;
  } res_t;

  typedef enum logic [2:0] {
    BK_FILL,
    BK_IDLE,
    BK_EXEC,
    BK_READ,
    BK_SCROLL,
    BK_BLANK
  } bk_state_t;

endpackage

FILE: rtl/tmcw_if.sv
// Request and response channel interfaces of the console writer.
`timescale 1ns / 1ps

interface tmcw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_code;
  logic       use_position;
  logic [7:0] col;
  logic [7:0] row;

  modport source (output valid, kind, char_code, use_position, col, row, input ready);
  modport sink   (input valid, kind, char_code, use_position, col, row, output ready);
endinterface

interface tmcw_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_char;
  logic [7:0]  read_attr;
  logic [10:0] cursor_cell;
  logic        range_error;
  logic        scrolled;

  modport source (output valid, read_char, read_attr, cursor_cell, range_error, scrolled,
                  input ready);
  modport sink   (input valid, read_char, read_attr, cursor_cell, range_error, scrolled,
                  output ready);
endinterface

FILE: rtl/text_mode_console_writer.sv
// Text mode console writer top level: config registers, front end, queue, screen engine.
//
// Usage: requests arrive on req (valid/ready). Each transfer carries kind (put character,
// backspace, clear screen, read cell), char_code, use_position and col/row. Every request
// gives exactly one result transfer on rsp with read data, the cursor cell after the step,
// a range error flag and a scroll flag. default_attr and error_attr are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while no request is in flight, which
// the block itself does not enforce. Path: a request passes the front register and the
// queue; the engine takes it in idle, and the result register loads in the execute state
// for put, newline, backspace and range errors, in the read state after it for a cell
// read, or at the end of the sweep when one runs. Throughput: the engine takes no new
// command until it is back in idle with the result register free. It walks the screen
// store one cell per cycle: a clear sweeps every cell, and a scroll copies rows up, then
// blanks a row. During a scroll the queue keeps taking requests until it fills; a clear
// holds req.ready low for its whole fill, like the reset pass.
// Reset: synchronous, active high. Registers return to 15 and 244, the cursor to cell 0,
// and the screen store is zeroed by a pass over all COLUMNS*ROWS cells, during which
// req.ready stays low. Config writes are taken at any time.
// Stall: a finished result waits in the output register; the engine picks up the next
// command in the cycle the result transfer completes.
`timescale 1ns / 1ps

module text_mode_console_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  tmcw_in_if.sink     req,
  tmcw_out_if.source  rsp
);
  import tmcw_pkg::*;

  logic [7:0] default_attr;
  logic [7:0] error_attr;
  logic       fill_busy;
  logic       f_valid;
  logic       f_ready;
  cmd_t       f_cmd;
  logic       q_valid;
  logic       q_ready;
  cmd_t       q_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= DEFAULT_ATTR_RESET;
      error_attr   <= ERROR_ATTR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEFAULT_ATTR) default_attr <= cfg_data;
      if (cfg_index == CFG_ERROR_ATTR)   error_attr   <= cfg_data;
    end
  end

  // Front end: range check and command decode
  tmcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (fill_busy),
    .req       (req),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  // Decoupling queue
  tmcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  // Screen engine
  tmcw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (q_valid),
    .cmd          (q_cmd),
    .cmd_ready    (q_ready),
    .default_attr (default_attr),
    .error_attr   (error_attr),
    .fill_busy    (fill_busy),
    .rsp          (rsp)
  );

  // No requests enter while the store is being swept by a fill
  a_no_accept_in_fill: assert property (@(posedge clk) disable iff (rst)
    fill_busy |-> !req.ready)
    else $error("request accepted during store fill");

  // A scroll always leaves the cursor at the start of the bottom row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.scrolled) |-> (rsp.cursor_cell == CURSOR_W'(TOTAL - COLUMNS)))
    else $error("cursor not on bottom row after scroll");

  // A range error never scrolls and never returns cell data
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.range_error) |->
      (!rsp.scrolled && rsp.read_char == 8'd0 && rsp.read_attr == 8'd0))
    else $error("range error result carries data or scroll");

  // The cursor stays inside the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.cursor_cell < CURSOR_W'(TOTAL)))
    else $error("cursor outside screen");

endmodule

FILE: rtl/tmcw_front.sv
// Front end: accepts requests, range-checks them and turns them into commands.
`timescale 1ns / 1ps

module tmcw_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            hold,
  tmcw_in_if.sink         req,
  output logic            cmd_valid,
  output tmcw_pkg::cmd_t  cmd,
  input  logic            cmd_ready
);
  import tmcw_pkg::*;

  logic bad;
  cmd_t cmd_next;

  assign req.ready = !hold && (!cmd_valid || cmd_ready);

  always_comb begin
    bad = req.use_position && (({1'b0, req.col} >= 9'(COLUMNS)) ||
                               ({1'b0, req.row} >= 9'(ROWS)));
    cmd_next.use_pos   = req.use_position;
    cmd_next.char_code = req.char_code;
    cmd_next.row       = req.row[ROW_W-1:0];
    cmd_next.col       = req.col[COL_W-1:0];
    cmd_next.op        = OP_PUT;
    unique case (kind_t'(req.kind))
      KIND_PUT: begin
        if (bad) begin
          cmd_next.op = OP_PUT_ERR;
        end else if (req.char_code == CHAR_NEWLINE) begin
          cmd_next.op = OP_NEWLINE;
        end else begin
          cmd_next.op = OP_PUT;
        end
      end
      KIND_BACKSPACE: begin
        cmd_next.op        = OP_BACKSPACE;
        cmd_next.char_code = CHAR_BS;
      end
      KIND_CLEAR: cmd_next.op = OP_CLEAR;
      KIND_READ:  cmd_next.op = bad ? OP_READ_ERR : OP_READ;
      default:    cmd_next.op = OP_PUT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req.ready) begin
      cmd_valid <= req.valid;
    end else if (cmd_ready) begin
      // held command drains into the queue while input is held off
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd <= cmd_next;
    end
  end

endmodule

FILE: rtl/tmcw_queue.sv
// Short command queue decoupling the front end from the screen engine.
`timescale 1ns / 1ps

module tmcw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  tmcw_pkg::cmd_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output tmcw_pkg::cmd_t  pop_data
);
  import tmcw_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign push_ready = (count != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/tmcw_back.sv
// Back end: screen store, cursor, scroll/clear sweeps and the result register.
`timescale 1ns / 1ps

module tmcw_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  tmcw_pkg::cmd_t  cmd,
  output logic            cmd_ready,
  input  logic [7:0]      default_attr,
  input  logic [7:0]      error_attr,
  output logic            fill_busy,
  tmcw_out_if.source      rsp
);
  import tmcw_pkg::*;

  localparam logic [CELL_W-1:0] LAST_CELL   = CELL_W'(TOTAL - 1);
  localparam logic [CELL_W-1:0] LAST_COPY   = CELL_W'(TOTAL - COLUMNS - 1);
  localparam logic [CELL_W-1:0] BOTTOM_ROW  = CELL_W'(TOTAL - COLUMNS);
  localparam logic [CELL_W-1:0] ROW_STRIDE  = CELL_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

  bk_state_t state, state_next;

  logic [15:0]       screen [TOTAL];
  logic [15:0]       rd_data;
  logic [CELL_W-1:0] rd_addr;
  logic              wr_en;
  logic [CELL_W-1:0] wr_addr;
  logic [15:0]       wr_data;

  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [CELL_W-1:0] cur_index;

  op_t               op;
  logic [7:0]        ch;
  logic [ROW_W-1:0]  trow;
  logic [COL_W-1:0]  tcol;
  logic [CELL_W-1:0] sweep;
  logic              cp_pend;
  logic [CELL_W-1:0] cp_addr;
  logic [15:0]       fill_word;
  logic              fill_report;
  logic              res_valid;
  res_t              res;

  logic [ROW_W-1:0]  sel_row;
  logic [COL_W-1:0]  sel_col;
  logic [CELL_W-1:0] ex_addr;
  logic [ROW_W:0]    nr_raw;
  logic [ROW_W-1:0]  nr;
  logic [COL_W-1:0]  nc;
  logic              wrap;
  logic [CELL_W-1:0] nidx;
  logic              take;

  // Target cell of the incoming command
  always_comb begin
    sel_row = cmd.use_pos ? cmd.row : cur_row;
    sel_col = cmd.use_pos ? cmd.col : cur_col;
    case (cmd.op)
      OP_BACKSPACE: begin
        if (cur_index == '0) begin
          sel_row = '0;
          sel_col = '0;
        end else if (cur_col == '0) begin
          sel_row = cur_row - 1'b1;
          sel_col = LAST_COL;
        end else begin
          sel_row = cur_row;
          sel_col = cur_col - 1'b1;
        end
      end
      OP_PUT_ERR: begin
        sel_row = LAST_ROW;
        sel_col = LAST_COL;
      end
      default: ;
    endcase
  end

  // Cell address and advanced cursor position
  always_comb begin
    ex_addr = CELL_W'(trow) * ROW_STRIDE + CELL_W'(tcol);
    if (op == OP_NEWLINE || tcol == LAST_COL) begin
      nr_raw = {1'b0, trow} + 1'b1;
      nc     = '0;
    end else begin
      nr_raw = {1'b0, trow};
      nc     = tcol + 1'b1;
    end
    wrap = (nr_raw == (ROW_W+1)'(ROWS));
    nr   = wrap ? LAST_ROW : nr_raw[ROW_W-1:0];
    nidx = CELL_W'(nr) * ROW_STRIDE + CELL_W'(nc);
  end

  assign take      = cmd_valid && cmd_ready;
  assign fill_busy = (state == BK_FILL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = ex_addr;
    wr_data    = {default_attr, ch};
    rd_addr    = ex_addr;
    unique case (state)
      BK_FILL: begin
        wr_en   = 1'b1;
        wr_addr = sweep;
        wr_data = fill_word;
        if (sweep == LAST_CELL) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        cmd_ready = !res_valid || rsp.ready;
        if (cmd_valid && cmd_ready) state_next = BK_EXEC;
      end
      BK_EXEC: begin
        unique case (op)
          OP_PUT, OP_BACKSPACE: begin
            wr_en      = 1'b1;
            state_next = wrap ? BK_SCROLL : BK_IDLE;
          end
          OP_NEWLINE: state_next = wrap ? BK_SCROLL : BK_IDLE;
          OP_PUT_ERR: begin
            wr_en      = 1'b1;
            wr_data    = {error_attr, CHAR_ERR};
            state_next = BK_IDLE;
          end
          OP_CLEAR:    state_next = BK_FILL;
          OP_READ:     state_next = BK_READ;
          OP_READ_ERR: state_next = BK_IDLE;
          default:     state_next = BK_IDLE;
        endcase
      end
      BK_READ: state_next = BK_IDLE;
      BK_SCROLL: begin
        rd_addr = sweep + ROW_STRIDE;
        wr_en   = cp_pend;
        wr_addr = cp_addr;
        wr_data = rd_data;
        if (sweep == LAST_COPY) state_next = BK_BLANK;
      end
      BK_BLANK: begin
        wr_en = 1'b1;
        if (cp_pend) begin
          wr_addr = cp_addr;
          wr_data = rd_data;
        end else begin
          wr_addr = sweep;
          wr_data = '0;
          if (sweep == LAST_CELL) state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Screen store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) screen[wr_addr] <= wr_data;
    rd_data <= screen[rd_addr];
  end

  // Command, cursor, sweep and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row     <= '0;
      cur_col     <= '0;
      cur_index   <= '0;
      sweep       <= '0;
      cp_pend     <= 1'b0;
      fill_word   <= '0;
      fill_report <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) res_valid <= 1'b0;
      case (state)
        BK_FILL: begin
          sweep <= sweep + 1'b1;
          if (sweep == LAST_CELL) begin
            sweep <= '0;
            if (fill_report) begin
              res_valid <= 1'b1;
              res       <= '{8'd0, 8'd0, CURSOR_W'(cur_index), 1'b0, 1'b0};
            end
          end
        end
        BK_IDLE: begin
          if (take) begin
            op   <= cmd.op;
            ch   <= cmd.char_code;
            trow <= sel_row;
            tcol <= sel_col;
          end
        end
        BK_EXEC: begin
          case (op)
            OP_PUT, OP_BACKSPACE, OP_NEWLINE: begin
              cur_row   <= nr;
              cur_col   <= nc;
              cur_index <= nidx;
              if (wrap) begin
                sweep   <= '0;
                cp_pend <= 1'b0;
              end else begin
                res_valid <= 1'b1;
                res       <= '{8'd0, 8'd0, CURSOR_W'(nidx), 1'b0, 1'b0};
              end
            end
            OP_PUT_ERR, OP_READ_ERR: begin
              res_valid <= 1'b1;
              res       <= '{8'd0, 8'd0, CURSOR_W'(cur_index), 1'b1, 1'b0};
            end
            OP_CLEAR: begin
              cur_row     <= '0;
              cur_col     <= '0;
              cur_index   <= '0;
              sweep       <= '0;
              fill_word   <= {default_attr, CHAR_SPACE};
              fill_report <= 1'b1;
            end
            default: ;
          endcase
        end
        BK_READ: begin
          res_valid <= 1'b1;
          res       <= '{rd_data[7:0], rd_data[15:8], CURSOR_W'(cur_index), 1'b0, 1'b0};
        end
        BK_SCROLL: begin
          cp_pend <= 1'b1;
          cp_addr <= sweep;
          sweep   <= (sweep == LAST_COPY) ? BOTTOM_ROW : sweep + 1'b1;
        end
        BK_BLANK: begin
          if (cp_pend) begin
            cp_pend <= 1'b0;
          end else begin
            sweep <= sweep + 1'b1;
            if (sweep == LAST_CELL) begin
              res_valid <= 1'b1;
              res       <= '{8'd0, 8'd0, CURSOR_W'(cur_index), 1'b0, 1'b1};
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid       = res_valid;
  assign rsp.read_char   = res.read_char;
  assign rsp.read_attr   = res.read_attr;
  assign rsp.cursor_cell = res.cursor_cell;
  assign rsp.range_error = res.range_error;
  assign rsp.scrolled    = res.scrolled;

endmodule

FILE: tb/tb_text_mode_console_writer.sv
// Self-checking bench for the text mode console writer with a screen-image predictor.
`timescale 1ns / 1ps

module tb_text_mode_console_writer;
  import tmcw_pkg::*;

  // One request as the bench sees it
  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_code;
    logic       use_pos;
    logic [7:0] col;
    logic [7:0] row;
  } console_cmd_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  tmcw_in_if  req ();
  tmcw_out_if rsp ();

  text_mode_console_writer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  // Predicted screen contents, cursor and attribute registers
  logic [15:0]   screen_img [TOTAL];
  logic [10:0]   cursor_pos;
  logic [7:0]    dflt_attr;
  logic [7:0]    err_attr;

  console_cmd_t  pending_cmds [$];     // waiting to be driven
  res_t          expected_results [$]; // predicted, waiting for the rsp transfer
  console_cmd_t  cur_cmd;

  int            send_gap;
  int            ready_stall;
  int            items_queued;
  int            accepted_cnt;
  int            results_seen;
  int            mismatch_cnt;
  logic          idle_on  = 1'b1;
  logic          hold_off = 1'b0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Writes a character (or advances on newline) at pos; scrolls when the
  // position runs off the bottom. Returns the scroll flag.
  function automatic logic place_char(int pos, logic [7:0] ch);
    logic rolled;
    rolled = 1'b0;
    if (ch == CHAR_NEWLINE) begin
      pos = (pos / COLUMNS + 1) * COLUMNS;
    end else begin
      if (pos < TOTAL) screen_img[pos] = {dflt_attr, ch};
      pos++;
    end
    if (pos >= TOTAL) begin
      for (int i = 0; i < TOTAL - COLUMNS; i++) screen_img[i] = screen_img[i + COLUMNS];
      for (int i = TOTAL - COLUMNS; i < TOTAL; i++) screen_img[i] = '0;
      pos -= COLUMNS;
      rolled = 1'b1;
    end
    cursor_pos = pos[10:0];
    return rolled;
  endfunction

  // Applies one accepted request to the screen image and queues its result
  function automatic void apply_console_cmd(console_cmd_t c);
    res_t r;
    logic bad;
    int   given;
    int   pos;
    r     = '0;
    bad   = c.use_pos && (c.col >= COLUMNS || c.row >= ROWS);
    given = int'(c.row) * COLUMNS + int'(c.col);
    case (c.kind)
      KIND_PUT: begin
        if (bad) begin
          // out-of-range put: error marker in the last cell, cursor stays
          screen_img[TOTAL-1] = {err_attr, CHAR_ERR};
          r.range_error = 1'b1;
        end else begin
          r.scrolled = place_char(c.use_pos ? given : int'(cursor_pos), c.char_code);
        end
      end
      KIND_BACKSPACE: begin
        // at cell zero the mark lands on cell zero and the cursor moves to 1
        r.scrolled = place_char((cursor_pos == 0) ? 0 : int'(cursor_pos) - 1, CHAR_BS);
      end
      KIND_CLEAR: begin
        for (int i = 0; i < TOTAL; i++) screen_img[i] = {dflt_attr, CHAR_SPACE};
        cursor_pos = '0;
      end
      default: begin
        if (bad) begin
          r.range_error = 1'b1;
        end else begin
          pos = c.use_pos ? given : int'(cursor_pos);
          r.read_char = screen_img[pos][7:0];
          r.read_attr = screen_img[pos][15:8];
        end
      end
    endcase
    r.cursor_cell = cursor_pos;
    expected_results.push_back(r);
  endfunction

  function automatic void queue_cmd(kind_t k, logic [7:0] ch, logic up,
                                    logic [7:0] col, logic [7:0] row);
    console_cmd_t c;
    c = '{kind: k, char_code: ch, use_pos: up, col: col, row: row};
    pending_cmds.push_back(c);
    items_queued++;
  endfunction

  // Register write while the block is drained; the predictor follows at once
  task automatic write_reg(cfg_reg_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_DEFAULT_ATTR: dflt_attr = val;
      default:          err_attr  = val;
    endcase
  endtask

  // Every request yields one result, so drained means counts agree
  task automatic wait_drained();
    while (results_seen < items_queued) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Driver: a transfer completes on valid & ready; predict it, then offer
  // the next request after a random gap.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        apply_console_cmd(cur_cmd);
        accepted_cnt++;
      end
      if (!req.valid || req.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd          = pending_cmds.pop_front();
          req.valid        <= 1'b1;
          req.kind         <= cur_cmd.kind;
          req.char_code    <= cur_cmd.char_code;
          req.use_position <= cur_cmd.use_pos;
          req.col          <= cur_cmd.col;
          req.row          <= cur_cmd.row;
          send_gap         = idle_on ? pick_gap() : 0;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each rsp transfer against the oldest prediction, then
  // decide whether to stall the next cycle.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{read_char: rsp.read_char, read_attr: rsp.read_attr,
                cursor_cell: rsp.cursor_cell, range_error: rsp.range_error,
                scrolled: rsp.scrolled};
        if (expected_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result with nothing expected: char %h attr %h cursor %0d err %b scr %b",
                     $realtime, got.read_char, got.read_attr, got.cursor_cell,
                     got.range_error, got.scrolled);
        end else begin
          want = expected_results.pop_front();
          results_seen++;
          if (got.read_char !== want.read_char || got.read_attr !== want.read_attr ||
              got.cursor_cell !== want.cursor_cell ||
              got.range_error !== want.range_error || got.scrolled !== want.scrolled) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: result %0d exp char %h attr %h cursor %0d err %b scr %b",
                       $realtime, results_seen, want.read_char, want.read_attr,
                       want.cursor_cell, want.range_error, want.scrolled);
              $display("%0t: result %0d got char %h attr %h cursor %0d err %b scr %b",
                       $realtime, results_seen, got.read_char, got.read_attr,
                       got.cursor_cell, got.range_error, got.scrolled);
            end
          end
        end
      end
      if (hold_off) begin
        rsp.ready <= 1'b0;
      end else if (ready_stall > 0) begin
        ready_stall--;
        rsp.ready <= 1'b0;
      end else if (idle_on && $urandom_range(99) < 20) begin
        ready_stall = pick_gap();
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off mid-run: front register and queue fill, req.ready drops
  initial begin
    wait (accepted_cnt >= 150);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: sized for the slowest legal run, with every request a clear or a scroll
  initial begin
    #(80_000_000);
    $display("status: fail");
    $finish;
  end

  initial begin
    int         roll;
    logic [7:0] ch;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] bad_col;
    logic [7:0] bad_row;

    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = CFG_DEFAULT_ATTR;
    cfg_data         = '0;
    req.valid        = 1'b0;
    req.kind         = KIND_PUT;
    req.char_code    = '0;
    req.use_position = 1'b0;
    req.col          = '0;
    req.row          = '0;
    rsp.ready        = 1'b0;
    for (int i = 0; i < TOTAL; i++) screen_img[i] = '0;
    cursor_pos   = '0;
    dflt_attr    = DEFAULT_ATTR_RESET;
    err_attr     = ERROR_ATTR_RESET;
    send_gap     = 0;
    ready_stall  = 0;
    items_queued = 0;
    accepted_cnt = 0;
    results_seen = 0;
    mismatch_cnt = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset attributes. The store clears itself after reset;
    // the driver just waits on req.ready.
    queue_cmd(KIND_READ,      8'h00, 1'b1, 8'd0,   8'd0);    // untouched cell reads zero
    queue_cmd(KIND_BACKSPACE, 8'h00, 1'b0, 8'd0,   8'd0);    // backspace at cell zero
    queue_cmd(KIND_PUT,       8'h48, 1'b0, 8'd0,   8'd0);
    queue_cmd(KIND_PUT,       8'hFF, 1'b0, 8'hFF,  8'hFF);
    queue_cmd(KIND_PUT,       8'h00, 1'b0, 8'd0,   8'd0);
    queue_cmd(KIND_BACKSPACE, 8'hFF, 1'b0, 8'd0,   8'd0);
    queue_cmd(KIND_READ,      8'h00, 1'b0, 8'd0,   8'd0);    // read at cursor
    queue_cmd(KIND_READ,      8'h00, 1'b1, 8'd0,   8'd0);
    queue_cmd(KIND_PUT,       CHAR_NEWLINE, 1'b0, 8'd0, 8'd0);
    queue_cmd(KIND_PUT,       8'h78, 1'b1, 8'd80,  8'd0);    // column one past the edge
    queue_cmd(KIND_PUT,       8'h79, 1'b1, 8'd0,   8'd25);   // row one past the edge
    queue_cmd(KIND_PUT,       8'h7A, 1'b1, 8'hFF,  8'hFF);
    queue_cmd(KIND_READ,      8'h00, 1'b1, 8'd79,  8'd24);   // error marker
    queue_cmd(KIND_READ,      8'h00, 1'b1, 8'd200, 8'd3);    // read out of range
    queue_cmd(KIND_READ,      8'h00, 1'b1, 8'd5,   8'hFF);
    queue_cmd(KIND_PUT,       8'h5A, 1'b1, 8'd79,  8'd24);   // last cell: scrolls
    queue_cmd(KIND_PUT,       CHAR_NEWLINE, 1'b1, 8'd10, 8'd24); // newline on bottom row
    queue_cmd(KIND_PUT,       CHAR_NEWLINE, 1'b0, 8'd0, 8'd0);
    queue_cmd(KIND_PUT,       8'h61, 1'b1, 8'd0,   8'd0);
    queue_cmd(KIND_CLEAR,     8'h00, 1'b0, 8'd0,   8'd0);
    queue_cmd(KIND_READ,      8'h00, 1'b1, 8'd79,  8'd24);
    queue_cmd(KIND_PUT,       CHAR_NEWLINE, 1'b1, 8'hFF, 8'd0); // bad position wins over newline
    queue_cmd(KIND_BACKSPACE, 8'h00, 1'b1, 8'hFF,  8'hFF);   // position fields ignored
    queue_cmd(KIND_CLEAR,     8'hFF, 1'b1, 8'hFF,  8'hFF);
    queue_cmd(KIND_BACKSPACE, 8'h00, 1'b0, 8'd0,   8'd0);    // cursor zero again after clear
    wait_drained();

    // Random phases, each with its own attribute setting
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          write_reg(CFG_DEFAULT_ATTR, 8'h00);
          write_reg(CFG_ERROR_ATTR,   8'hFF);
        end
        1: begin
          write_reg(CFG_DEFAULT_ATTR, 8'hFF);
          write_reg(CFG_ERROR_ATTR,   8'h00);
        end
        3: begin
          write_reg(CFG_DEFAULT_ATTR, DEFAULT_ATTR_RESET);
          write_reg(CFG_ERROR_ATTR,   ERROR_ATTR_RESET);
        end
        default: begin
          write_reg(CFG_DEFAULT_ATTR, 8'($urandom));
          write_reg(CFG_ERROR_ATTR,   8'($urandom));
        end
      endcase
      idle_on <= (p != 2);  // one phase runs with no gaps or stalls at all

      for (int n = 0; n < 120; n++) begin
        roll = $urandom_range(99);
        ch   = ($urandom_range(9) < 8) ? 8'($urandom_range(126, 32)) : 8'($urandom);
        col  = 8'($urandom_range(COLUMNS - 1));
        // bias toward the bottom row so newlines there scroll
        row  = ($urandom_range(9) < 3) ? 8'(ROWS - 1) : 8'($urandom_range(ROWS - 1));
        bad_col = 8'($urandom);
        bad_row = 8'($urandom);
        if (bad_col < COLUMNS && bad_row < ROWS) bad_col = 8'($urandom_range(255, COLUMNS));

        if (roll < 50)
          queue_cmd(KIND_PUT, ch, 1'b0, 8'($urandom), 8'($urandom));
        else if (roll < 58)
          queue_cmd(KIND_PUT, CHAR_NEWLINE, 1'b0, 8'($urandom), 8'($urandom));
        else if (roll < 70)
          queue_cmd(KIND_PUT, ($urandom_range(6) == 0) ? CHAR_NEWLINE : ch, 1'b1, col, row);
        else if (roll < 74)
          queue_cmd(KIND_PUT, 8'($urandom), 1'b1, bad_col, bad_row);
        else if (roll < 81)
          queue_cmd(KIND_BACKSPACE, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
        else if (roll < 83)
          queue_cmd(KIND_CLEAR, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
        else if (roll < 88)
          queue_cmd(KIND_READ, 8'($urandom), 1'b0, 8'($urandom), 8'($urandom));
        else if (roll < 95)
          queue_cmd(KIND_READ, 8'($urandom), 1'b1, col, row);
        else if (roll < 98)
          queue_cmd(KIND_READ, 8'($urandom), 1'b1, bad_col, bad_row);
        else
          queue_cmd(kind_t'($urandom_range(3)), 8'($urandom), 1'($urandom),
                    8'($urandom), 8'($urandom));
      end
      wait_drained();
    end

    // settle: any stray result would show up as unexpected here
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
